@@ sv/gbfs_pkg.sv @@
// Shared types and constants for the breadth-first traversal block.
package gbfs_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VID_W            = 6;
  localparam int CFG_W            = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_U,
    ST_WR_V,
    ST_SCAN,
    ST_POP,
    ST_NODE,
    ST_ROW,
    ST_PUSH,
    ST_CLEAR
  } state_t;

endpackage

@@ sv/gbfs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/graph_bfs_order.sv @@
// Breadth-first traversal of an undirected graph held as an adjacency bit matrix in RAM.
//
// After reset the block holds busy high while it zeroes the adjacency RAM. Each beat on the
// input carries at most one edge. A valid edge between two distinct vertices raises busy while
// both adjacency rows are read, updated and written back; unless it is marked last, a beat without
// an edge leaves busy low. The beat marked last starts the traversal: the block scans the start
// slots below the configured vertex count, and for each visited vertex it reads the queue, reads
// and loads the vertex's row and pushes each unvisited neighbor onto the queue before a final
// neighbor check. An empty-queue check ends each start point, and a sweep then clears the
// adjacency RAM. Results leave as one-cycle strobes on out_valid that cannot be stalled; the last
// vertex is flagged with out_last_vertex. start is ignored while busy is high.
module graph_bfs_order #(
  parameter int MAX_VERTICES = gbfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_edge_valid,
  input  logic [gbfs_pkg::VID_W-1:0]  in_edge_u,
  input  logic [gbfs_pkg::VID_W-1:0]  in_edge_v,
  input  logic                        in_last_edge,
  output logic                        out_valid,
  output logic [gbfs_pkg::VID_W-1:0]  out_vertex_id,
  output logic                        out_last_vertex,
  input  logic                        cfg_wr_en,
  input  logic [gbfs_pkg::CFG_W-1:0]  cfg_wr_data
);

  import gbfs_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        cfg_nv_r;
  logic [IW-1:0]           eu_r, eu_nxt, ev_r, ev_nxt;
  logic                    last_r, last_nxt;
  logic [CW-1:0]           scan_r, scan_nxt;
  logic [CW-1:0]           head_r, head_nxt, tail_r, tail_nxt;
  logic [MAX_VERTICES-1:0] row_r, row_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [IW-1:0]           held_r, held_nxt;
  logic                    held_vld_r, held_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VID_W-1:0]        out_vid_r, out_vid_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [IW-1:0]           clr_r, clr_nxt;

  logic                    adj_wr_en;
  logic [IW-1:0]           adj_wr_addr, adj_rd_addr;
  logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data;
  logic                    q_wr_en;
  logic [IW-1:0]           q_wr_addr, q_rd_addr, q_wr_data, q_rd_data;

  logic [CW-1:0]           limit;
  logic [MAX_VERTICES-1:0] pend;
  logic [IW-1:0]           pick;
  logic [IW-1:0]           scan_idx;
  logic                    edge_ok;

  function automatic logic [IW-1:0] first_set(input logic [MAX_VERTICES-1:0] w);
    logic [IW-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = IW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [MAX_VERTICES-1:0] bit_of(input logic [IW-1:0] idx);
    return {{(MAX_VERTICES-1){1'b0}}, 1'b1} << idx;
  endfunction

  gbfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES), .AW(IW)) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  gbfs_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES), .AW(IW)) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  assign limit    = (cfg_nv_r > CFG_W'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(cfg_nv_r);
  assign pend     = row_r & ~visited_r;
  assign pick     = first_set(pend);
  assign scan_idx = scan_r[IW-1:0];
  assign edge_ok  = in_edge_valid && (in_edge_u != in_edge_v) &&
                    ({1'b0, in_edge_u} < CFG_W'(MAX_VERTICES)) &&
                    ({1'b0, in_edge_v} < CFG_W'(MAX_VERTICES));

  always_comb begin
    state_nxt     = state_r;
    eu_nxt        = eu_r;
    ev_nxt        = ev_r;
    last_nxt      = last_r;
    scan_nxt      = scan_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    row_nxt       = row_r;
    visited_nxt   = visited_r;
    held_nxt      = held_r;
    held_vld_nxt  = held_vld_r;
    out_valid_nxt = 1'b0;
    out_vid_nxt   = out_vid_r;
    out_last_nxt  = out_last_r;
    clr_nxt       = clr_r;
    adj_wr_en     = 1'b0;
    adj_wr_addr   = eu_r;
    adj_wr_data   = '0;
    adj_rd_addr   = in_edge_u[IW-1:0];
    q_wr_en       = 1'b0;
    q_wr_addr     = tail_r[IW-1:0];
    q_wr_data     = pick;
    q_rd_addr     = head_r[IW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          eu_nxt   = in_edge_u[IW-1:0];
          ev_nxt   = in_edge_v[IW-1:0];
          last_nxt = in_last_edge;
          scan_nxt = '0;
          if (edge_ok) begin
            state_nxt = ST_WR_U;
          end else if (in_last_edge) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_WR_U: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = eu_r;
        adj_wr_data = adj_rd_data | bit_of(ev_r);
        adj_rd_addr = ev_r;
        state_nxt   = ST_WR_V;
      end
      ST_WR_V: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = ev_r;
        adj_wr_data = adj_rd_data | bit_of(eu_r);
        state_nxt   = last_r ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_r < limit) begin
          scan_nxt = scan_r + CW'(1);
          if (!visited_r[scan_idx]) begin
            visited_nxt[scan_idx] = 1'b1;
            q_wr_en   = 1'b1;
            q_wr_addr = '0;
            q_wr_data = scan_idx;
            head_nxt  = '0;
            tail_nxt  = CW'(1);
            state_nxt = ST_POP;
          end
        end else begin
          if (held_vld_r) begin
            out_valid_nxt = 1'b1;
            out_vid_nxt   = VID_W'(held_r);
            out_last_nxt  = 1'b1;
          end
          held_vld_nxt = 1'b0;
          visited_nxt  = '0;
          clr_nxt      = '0;
          state_nxt    = ST_CLEAR;
        end
      end
      ST_POP: begin
        state_nxt = (head_r == tail_r) ? ST_SCAN : ST_NODE;
      end
      ST_NODE: begin
        adj_rd_addr = q_rd_data;
        if (held_vld_r) begin
          out_valid_nxt = 1'b1;
          out_vid_nxt   = VID_W'(held_r);
          out_last_nxt  = 1'b0;
        end
        held_nxt     = q_rd_data;
        held_vld_nxt = 1'b1;
        head_nxt     = head_r + CW'(1);
        state_nxt    = ST_ROW;
      end
      ST_ROW: begin
        row_nxt   = adj_rd_data;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (pend == '0) begin
          state_nxt = ST_POP;
        end else begin
          visited_nxt[pick] = 1'b1;
          q_wr_en           = 1'b1;
          tail_nxt          = tail_r + CW'(1);
        end
      end
      ST_CLEAR: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = clr_r;
        adj_wr_data = '0;
        clr_nxt     = clr_r + IW'(1);
        if (clr_r == IW'(MAX_VERTICES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cfg_nv_r    <= '0;
      scan_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      visited_r   <= '0;
      held_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        cfg_nv_r <= cfg_wr_data;
      end
      scan_r      <= scan_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      visited_r   <= visited_nxt;
      held_vld_r  <= held_vld_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eu_r       <= eu_nxt;
    ev_r       <= ev_nxt;
    last_r     <= last_nxt;
    row_r      <= row_nxt;
    held_r     <= held_nxt;
    out_vid_r  <= out_vid_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_vertex_id   = out_vid_r;
  assign out_last_vertex = out_last_r;

`ifndef SYNTHESIS
  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_vertex) |=> !out_valid)
    else $error("result beat after the final vertex");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= CW'(MAX_VERTICES))
    else $error("queue overflow");
`endif

endmodule

@@ verif/graph_bfs_checker.sv @@
// Checker for graph_bfs_order: models the adjacency matrix and compares the visit order.
`timescale 1ns / 1ps
module graph_bfs_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_edge_valid,
  input  logic [gbfs_pkg::VID_W-1:0]  in_edge_u,
  input  logic [gbfs_pkg::VID_W-1:0]  in_edge_v,
  input  logic                        in_last_edge,
  input  logic                        out_valid,
  input  logic [gbfs_pkg::VID_W-1:0]  out_vertex_id,
  input  logic                        out_last_vertex,
  input  logic                        cfg_wr_en,
  input  logic [gbfs_pkg::CFG_W-1:0]  cfg_wr_data,
  output int                          fail_count,
  output int                          pending_beats
);

  localparam int VERTEX_SLOTS = gbfs_pkg::MAX_VERTICES_DEF;

  typedef struct packed {
    logic [gbfs_pkg::VID_W-1:0] vertex;
    logic                       is_last;
  } visit_t;

  logic [VERTEX_SLOTS-1:0]    adj_rows [VERTEX_SLOTS];
  logic [gbfs_pkg::CFG_W-1:0] vertex_count;
  visit_t                     visit_order_q [$];
  visit_t                     exp_beat;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic add_edge(input logic [gbfs_pkg::VID_W-1:0] u,
                          input logic [gbfs_pkg::VID_W-1:0] v);
    if (u != v) begin
      adj_rows[u][v] = 1'b1;
      adj_rows[v][u] = 1'b1;
    end
  endtask

  task automatic predict_visit_order();
    logic [VERTEX_SLOTS-1:0]    seen;
    logic [gbfs_pkg::VID_W-1:0] fifo [VERTEX_SLOTS];
    logic [gbfs_pkg::VID_W-1:0] order [VERTEX_SLOTS];
    logic [gbfs_pkg::VID_W-1:0] node;
    visit_t                     beat;
    int                         head;
    int                         tail;
    int                         scan_end;
    int                         n_out;
    seen = '0;
    n_out = 0;
    scan_end = (vertex_count > VERTEX_SLOTS) ? VERTEX_SLOTS : int'(vertex_count);
    for (int s = 0; s < scan_end; s++) begin
      if (!seen[s]) begin
        head = 0;
        tail = 0;
        seen[s] = 1'b1;
        fifo[tail] = s[gbfs_pkg::VID_W-1:0];
        tail++;
        while (head != tail) begin
          node = fifo[head];
          head++;
          order[n_out] = node;
          n_out++;
          for (int n = 0; n < VERTEX_SLOTS; n++) begin
            if (adj_rows[node][n] && !seen[n]) begin
              seen[n] = 1'b1;
              fifo[tail] = n[gbfs_pkg::VID_W-1:0];
              tail++;
            end
          end
        end
      end
    end
    for (int i = 0; i < n_out; i++) begin
      beat.vertex = order[i];
      beat.is_last = (i == n_out - 1);
      visit_order_q = {visit_order_q, beat};
    end
    for (int r = 0; r < VERTEX_SLOTS; r++) adj_rows[r] = '0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < VERTEX_SLOTS; r++) adj_rows[r] = '0;
      vertex_count = '0;
      visit_order_q.delete();
    end else begin
      if (cfg_wr_en) vertex_count = cfg_wr_data;
      if (start && !busy) begin
        if (in_edge_valid) add_edge(in_edge_u, in_edge_v);
        if (in_last_edge) predict_visit_order();
      end
      if (out_valid) begin
        if (visit_order_q.size() == 0) begin
          report_mismatch($sformatf("vertex %0d arrived with nothing expected", out_vertex_id));
        end else begin
          exp_beat = visit_order_q.pop_front();
          if (out_vertex_id !== exp_beat.vertex)
            report_mismatch($sformatf("out_vertex_id %0d, expected %0d",
                                      out_vertex_id, exp_beat.vertex));
          if (out_last_vertex !== exp_beat.is_last)
            report_mismatch($sformatf("out_last_vertex %0b on vertex %0d, expected %0b",
                                      out_last_vertex, exp_beat.vertex, exp_beat.is_last));
        end
      end
    end
    pending_beats = visit_order_q.size();
  end

endmodule

@@ verif/tb.sv @@
// Top-level testbench for graph_bfs_order: edge stimulus, vertex count phases and the verdict.
`timescale 1ns / 1ps
module tb;

  localparam int          SETTLE_CYCLES = gbfs_pkg::MAX_VERTICES_DEF + 32;
  localparam int unsigned RUN_LIMIT     = 400000;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_BEATS   = 13;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic                       in_edge_valid;
  logic [gbfs_pkg::VID_W-1:0] in_edge_u;
  logic [gbfs_pkg::VID_W-1:0] in_edge_v;
  logic                       in_last_edge;
  logic                       out_valid;
  logic [gbfs_pkg::VID_W-1:0] out_vertex_id;
  logic                       out_last_vertex;
  logic                       cfg_wr_en;
  logic [gbfs_pkg::CFG_W-1:0] cfg_wr_data;
  int                         fail_count;
  int                         pending_beats;
  int unsigned                cycle_count = 0;
  int                         beats_sent = 0;
  logic                       quiet_phase = 1'b0;
  int                         phase_counts [5] = '{64, 127, 1, 65, 12};
  int                         phase_target;

  always #4 clk = ~clk;

  graph_bfs_order u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_edge_valid   (in_edge_valid),
    .in_edge_u       (in_edge_u),
    .in_edge_v       (in_edge_v),
    .in_last_edge    (in_last_edge),
    .out_valid       (out_valid),
    .out_vertex_id   (out_vertex_id),
    .out_last_vertex (out_last_vertex),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  graph_bfs_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_edge_valid   (in_edge_valid),
    .in_edge_u       (in_edge_u),
    .in_edge_v       (in_edge_v),
    .in_last_edge    (in_last_edge),
    .out_valid       (out_valid),
    .out_vertex_id   (out_vertex_id),
    .out_last_vertex (out_last_vertex),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending_beats   (pending_beats)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("** graph_bfs_order: FAILED **");
      $finish;
    end
  end

  task automatic pause_beats(input int n);
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      start <= 1'b0;
      in_edge_valid <= 1'($urandom);
      in_edge_u <= 6'($urandom);
      in_edge_v <= 6'($urandom);
      in_last_edge <= 1'($urandom);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 65) return;
    if (r < 94) pause_beats($urandom_range(1, 3));
    else pause_beats($urandom_range(8, 40));
  endtask

  task automatic send_beat(input logic valid, input logic [gbfs_pkg::VID_W-1:0] u,
                           input logic [gbfs_pkg::VID_W-1:0] v, input logic last);
    @(negedge clk);
    start <= 1'b1;
    in_edge_valid <= valid;
    in_edge_u <= u;
    in_edge_v <= v;
    in_last_edge <= last;
    do @(posedge clk); while (busy !== 1'b0);
    beats_sent++;
    random_gap();
  endtask

  task automatic drain_pending();
    @(negedge clk);
    start <= 1'b0;
    while (pending_beats != 0 || busy !== 1'b0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_vertex_count(input int count);
    drain_pending();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 7'(count);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_graph();
    int n_edges;
    int lo;
    int hi;
    int r;
    logic [gbfs_pkg::VID_W-1:0] u;
    logic [gbfs_pkg::VID_W-1:0] v;
    n_edges = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(20, 60);
    r = $urandom_range(0, 9);
    if (r < 5) begin
      lo = $urandom_range(0, 56);
      hi = lo + 7;
    end else if (r < 8) begin
      lo = 0;
      hi = 15;
    end else begin
      lo = 0;
      hi = 63;
    end
    for (int i = 0; i < n_edges; i++) begin
      r = $urandom_range(0, 15);
      u = 6'($urandom_range(lo, hi));
      v = 6'($urandom_range(lo, hi));
      if (r == 0) send_beat(1'b0, 6'($urandom), 6'($urandom), 1'b0);
      else if (r == 1) send_beat(1'b1, u, u, 1'b0);
      else send_beat(1'b1, u, v, 1'b0);
    end
    u = 6'($urandom_range(lo, hi));
    v = 6'($urandom_range(lo, hi));
    send_beat(($urandom_range(0, 9) < 7), u, v, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_edge_valid = 1'b0;
    in_edge_u = '0;
    in_edge_v = '0;
    in_last_edge = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With no start points the traversal emits nothing but must still clear the graph.
    send_beat(1'b1, 6'd0, 6'd1, 1'b0);
    send_beat(1'b0, 6'd63, 6'd63, 1'b1);

    set_vertex_count(8);
    send_beat(1'b1, 6'd0, 6'd63, 1'b0);
    send_beat(1'b1, 6'd63, 6'd0, 1'b0);
    send_beat(1'b1, 6'd5, 6'd5, 1'b0);
    send_beat(1'b0, 6'd63, 6'd63, 1'b0);
    send_beat(1'b1, 6'd1, 6'd2, 1'b0);
    send_beat(1'b1, 6'd2, 6'd3, 1'b1);
    send_beat(1'b0, 6'd0, 6'd0, 1'b1);

    set_vertex_count(127);
    send_beat(1'b1, 6'd62, 6'd63, 1'b0);
    send_beat(1'b1, 6'd0, 6'd63, 1'b1);

    set_vertex_count(64);
    send_beat(1'b1, 6'd10, 6'd0, 1'b0);
    send_beat(1'b1, 6'd10, 6'd63, 1'b0);
    send_beat(1'b1, 6'd10, 6'd42, 1'b0);
    send_beat(1'b1, 6'd42, 6'd0, 1'b0);
    send_beat(1'b1, 6'd21, 6'd42, 1'b1);

    set_vertex_count(1);
    send_beat(1'b1, 6'd40, 6'd41, 1'b0);
    send_beat(1'b1, 6'd41, 6'd1, 1'b0);
    send_beat(1'b1, 6'd1, 6'd0, 1'b1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_vertex_count((ph < 5) ? phase_counts[ph] : $urandom_range(0, 127));
      quiet_phase = (ph % 3 == 2);
      phase_target = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_target) send_graph();
    end

    drain_pending();
    if (fail_count == 0 && pending_beats == 0) begin
      $display("** graph_bfs_order: PASSED **");
    end else begin
      $display("** graph_bfs_order: FAILED **");
    end
    $finish;
  end

endmodule
